// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion macros for the radix sorter blocks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Checked at every rising edge outside of reset.
`define ASSERT_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked at every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== src/drs_pkg.sv =====
// ----------------------------------------------------------------------------
// drs_pkg
// Types, constants and the digit split shared by the decimal radix sorter.
// ----------------------------------------------------------------------------
package drs_pkg;

  localparam int MAX_ITEMS    = 64;
  localparam int DIGIT_PASSES = 3;
  localparam int RADIX        = 10;
  localparam int VALUE_W      = 10;
  localparam int DIG_W        = 4;
  localparam int ADDR_W       = $clog2(MAX_ITEMS);
  localparam int CNT_W        = $clog2(MAX_ITEMS + 1);
  localparam int PASS_W       = (DIGIT_PASSES > 1) ? $clog2(DIGIT_PASSES) : 1;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [VALUE_W-1:0] VALUE_MAX = VALUE_W'(999);

  typedef logic [DIGIT_PASSES-1:0][DIG_W-1:0] digits_t;

  // One stored value together with its decimal digits, units first.
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    digits_t            digits;
  } elem_t;

  // One beat handed from the front end to the sort engine.
  typedef struct packed {
    elem_t elem;
    logic  drop;
    logic  last;
  } qent_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_COUNT,
    S_PREFIX,
    S_SCATTER,
    S_EMIT_RD,
    S_EMIT_WR
  } back_state_t;

  // Splits a value of at most 999 into units, tens and hundreds with nine
  // parallel compares for each of the hundreds and tens digits instead of a divider.
  function automatic digits_t to_digits(logic [VALUE_W-1:0] v);
    logic [DIG_W-1:0]   h;
    logic [DIG_W-1:0]   t;
    logic [DIG_W-1:0]   u;
    logic [VALUE_W-1:0] rem;
    digits_t            d;
    h = '0;
    t = '0;
    for (int k = 1; k < RADIX; k++) begin
      if (v >= VALUE_W'(k * RADIX * RADIX)) h = DIG_W'(k);
    end
    rem = v - VALUE_W'(h) * VALUE_W'(RADIX * RADIX);
    for (int k = 1; k < RADIX; k++) begin
      if (rem >= VALUE_W'(k * RADIX)) t = DIG_W'(k);
    end
    u = DIG_W'(rem - VALUE_W'(t) * VALUE_W'(RADIX));
    for (int p = 0; p < DIGIT_PASSES; p++) begin
      case (p)
        0:       d[p] = u;
        1:       d[p] = t;
        2:       d[p] = h;
        default: d[p] = '0;
      endcase
    end
    return d;
  endfunction

endpackage

// ===== src/drs_front.sv =====
// ----------------------------------------------------------------------------
// drs_front
// Input front end: takes beats, saturates the value, splits it into digits
// and marks beats that arrive once the set already fills the store.
// ----------------------------------------------------------------------------
module drs_front import drs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [VALUE_W-1:0] value,
  input  logic               last_item,
  input  logic               q_full,
  output logic               push,
  output qent_t              push_data
);

  logic [CNT_W-1:0]   fill;
  logic [VALUE_W-1:0] sat;

  assign sat      = (value > VALUE_MAX) ? VALUE_MAX : value;
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    push_data.elem.value  = sat;
    push_data.elem.digits = to_digits(sat);
    push_data.drop        = (fill == CNT_W'(MAX_ITEMS));
    push_data.last        = last_item;
  end

  // Fill level of the set as seen at the input; the final beat restarts it.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (push) begin
      if (last_item) begin
        fill <= '0;
      end else if (!push_data.drop) begin
        fill <= fill + CNT_W'(1);
      end
    end
  end

endmodule

// ===== src/drs_fifo.sv =====
// ----------------------------------------------------------------------------
// drs_fifo
// Short queue between the front end and the sort engine.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module drs_fifo import drs_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  qent_t push_data,
  output logic  full,
  input  logic  pop,
  output qent_t pop_data,
  output logic  empty
);

  qent_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] fill;

  assign full     = (fill == QCNT_W'(QUEUE_DEPTH));
  assign empty    = (fill == '0);
  assign pop_data = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) wptr <= wptr + QPTR_W'(1);
      if (pop)  rptr <= rptr + QPTR_W'(1);
      if (push && !pop) begin
        fill <= fill + QCNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - QCNT_W'(1);
      end
    end
  end

  `ASSERT_RST(a_no_push_full, clk, rst, push |-> !full, "push into a full queue")
  `ASSERT_RST(a_no_pop_empty, clk, rst, pop |-> !empty, "pop from an empty queue")
  `ASSERT_RST(a_fill_bound, clk, rst, fill <= QCNT_W'(QUEUE_DEPTH), "queue fill out of range")

endmodule

// ===== src/drs_back.sv =====
// ----------------------------------------------------------------------------
// drs_back
// Sort engine: loads the set into a ping-pong pair of memories, runs one
// count, prefix and scatter pass per digit, then streams the result out.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module drs_back import drs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  qent_t              q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [VALUE_W-1:0] sorted_value,
  output logic               last_result,
  output logic               overflow
);

  back_state_t       state;
  back_state_t       state_next;
  logic [CNT_W-1:0]  count;
  logic              ovf;
  logic              bank;
  logic [PASS_W-1:0] pass;
  logic [CNT_W-1:0]  idx;
  logic              rd_vld;
  logic [CNT_W-1:0]  cnt [RADIX];
  logic [CNT_W-1:0]  acc;
  logic [DIG_W-1:0]  k;

  elem_t mem_a [MAX_ITEMS];
  elem_t mem_b [MAX_ITEMS];
  elem_t rd_a;
  elem_t rd_b;

  logic              issue;
  logic              we;
  logic              wsel;
  logic [ADDR_W-1:0] waddr;
  elem_t             wdata;
  logic [ADDR_W-1:0] raddr;
  elem_t             rdata;
  logic [DIG_W-1:0]  dig;
  logic              emit_load;
  logic              emit_final;
  logic              pass_last;

  assign rdata      = bank ? rd_b : rd_a;
  assign dig        = rdata.digits[pass];
  assign raddr      = idx[ADDR_W-1:0];
  assign pass_last  = (pass == PASS_W'(DIGIT_PASSES - 1));
  assign emit_final = (idx + CNT_W'(1) == count);

  // Control outputs of the sequencer.
  always_comb begin
    q_pop     = 1'b0;
    issue     = 1'b0;
    we        = 1'b0;
    wsel      = bank;
    waddr     = count[ADDR_W-1:0];
    wdata     = q_data.elem;
    emit_load = 1'b0;
    case (state)
      S_LOAD: begin
        q_pop = !q_empty;
        we    = !q_empty && !q_data.drop;
      end
      S_COUNT: begin
        issue = (idx < count);
      end
      S_SCATTER: begin
        issue = (idx < count);
        we    = rd_vld;
        wsel  = !bank;
        waddr = cnt[dig][ADDR_W-1:0];
        wdata = rdata;
      end
      S_EMIT_WR: begin
        emit_load = !out_valid || !out_stall;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_LOAD: begin
        if (q_pop && q_data.last) state_next = S_COUNT;
      end
      S_COUNT: begin
        if (!issue && !rd_vld) state_next = S_PREFIX;
      end
      S_PREFIX: begin
        if (k == DIG_W'(RADIX - 1)) state_next = S_SCATTER;
      end
      S_SCATTER: begin
        if (!issue && !rd_vld) state_next = pass_last ? S_EMIT_RD : S_COUNT;
      end
      S_EMIT_RD: begin
        state_next = S_EMIT_WR;
      end
      S_EMIT_WR: begin
        if (emit_load) state_next = emit_final ? S_LOAD : S_EMIT_RD;
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  // Both banks are read every cycle; the bank bit picks the source.
  always_ff @(posedge clk) begin
    if (we && !wsel) mem_a[waddr] <= wdata;
    if (we && wsel)  mem_b[waddr] <= wdata;
    rd_a <= mem_a[raddr];
    rd_b <= mem_b[raddr];
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      sorted_value <= rdata.value;
      last_result  <= emit_final;
      overflow     <= ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      count     <= '0;
      ovf       <= 1'b0;
      bank      <= 1'b0;
      pass      <= '0;
      idx       <= '0;
      rd_vld    <= 1'b0;
      acc       <= '0;
      k         <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < RADIX; i++) cnt[i] <= '0;
    end else begin
      state  <= state_next;
      rd_vld <= issue;
      if (emit_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_LOAD: begin
          if (q_pop) begin
            if (q_data.drop) begin
              ovf <= 1'b1;
            end else begin
              count <= count + CNT_W'(1);
            end
            if (q_data.last) begin
              idx  <= '0;
              pass <= '0;
              for (int i = 0; i < RADIX; i++) cnt[i] <= '0;
            end
          end
        end
        S_COUNT: begin
          if (issue)  idx <= idx + CNT_W'(1);
          if (rd_vld) cnt[dig] <= cnt[dig] + CNT_W'(1);
          if (state_next == S_PREFIX) begin
            k   <= '0;
            acc <= '0;
          end
        end
        S_PREFIX: begin
          // Turns bucket sizes into bucket start addresses in place.
          cnt[k] <= acc;
          acc    <= acc + cnt[k];
          k      <= k + DIG_W'(1);
          idx    <= '0;
        end
        S_SCATTER: begin
          if (issue)  idx <= idx + CNT_W'(1);
          if (rd_vld) cnt[dig] <= cnt[dig] + CNT_W'(1);
          if (state_next != S_SCATTER) begin
            bank <= !bank;
            pass <= pass_last ? '0 : pass + PASS_W'(1);
            idx  <= '0;
            for (int i = 0; i < RADIX; i++) cnt[i] <= '0;
          end
        end
        S_EMIT_WR: begin
          if (emit_load) begin
            idx <= idx + CNT_W'(1);
            if (emit_final) begin
              count <= '0;
              ovf   <= 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  `ASSERT_RST(a_count_bound, clk, rst, count <= CNT_W'(MAX_ITEMS), "item count above capacity")
  `ASSERT_RST(a_prefix_total, clk, rst, (state == S_PREFIX && state_next == S_SCATTER) |=> acc == count, "bucket sizes do not add up to the set size")
  `ASSERT_RST(a_scatter_end, clk, rst, (state == S_SCATTER && state_next != S_SCATTER) |-> cnt[RADIX-1] == count, "scatter did not place every value")

endmodule

// ===== src/decimal_lsd_radix_sort.sv =====
// ----------------------------------------------------------------------------
// decimal_lsd_radix_sort
// Stable base-ten radix sorter for sets of up to 64 values of 0 to 999.
// ----------------------------------------------------------------------------
// Input beats carry value and last_item on in_valid / in_stall; a beat is
// taken at a clock edge with in_valid high and in_stall low. Values above 999
// are stored as 999. Beats past the 64th of a set are dropped and every result
// of that set then carries overflow. The beat with last_item closes the set.
// Input beats are taken one per cycle through a four-entry queue while the
// engine is loading; while a set is sorted the queue fills and in_stall rises.
// The set of n values is sorted with one count, prefix and scatter pass per
// digit, each pass bounded by the single read port of each of the two
// ping-pong memories. The results then leave on out_valid / out_stall, each
// read from memory before it is loaded into the output register, last_result
// on the final one. A stalled result holds in the output register while the
// engine waits. A synchronous reset empties the queue, drops any set in
// progress and clears the output valid; no memory clearing is needed.
// ----------------------------------------------------------------------------
module decimal_lsd_radix_sort import drs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [VALUE_W-1:0] value,
  input  logic               last_item,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [VALUE_W-1:0] sorted_value,
  output logic               last_result,
  output logic               overflow
);

  logic  push;
  qent_t push_data;
  logic  q_full;
  logic  q_pop;
  qent_t q_data;
  logic  q_empty;

  drs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .value     (value),
    .last_item (last_item),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  drs_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  drs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_data       (q_data),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sorted_value (sorted_value),
    .last_result  (last_result),
    .overflow     (overflow)
  );

endmodule
